// ----- src/mpsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsf_pkg: shared types and constants of the pixel sample fetch unit
// Item layouts of both channels, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
package mpsf_pkg;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [1:0]  chan;
        logic [15:0] frame_index;
        logic [31:0] raw_word;
        logic        restart;
    } req_item_t;

    typedef struct packed {
        logic [31:0]        byte_offset;
        logic signed [31:0] sample_value;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
    } rsp_item_t;

    // configuration register indexes
    localparam logic [2:0] REG_BITS_STORED     = 3'd0;
    localparam logic [2:0] REG_BYTES_PER_VALUE = 3'd1;
    localparam logic [2:0] REG_RIGHT_SHIFT     = 3'd2;
    localparam logic [2:0] REG_IS_SIGNED       = 3'd3;
    localparam logic [2:0] REG_IS_PLANAR       = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd6;
    localparam logic [2:0] REG_FRAME_BYTES     = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

    // multiply steps of the offset sequencer
    localparam logic [2:0] STEP_FRAME  = 3'd0;
    localparam logic [2:0] STEP_STRIDE = 3'd1;
    localparam logic [2:0] STEP_ROW    = 3'd2;
    localparam logic [2:0] STEP_COL    = 3'd3;
    localparam logic [2:0] STEP_CHAN   = 3'd4;

    localparam int unsigned     DIV_BITS  = 34;
    localparam logic [5:0]      DIV_STEPS = 6'd34;
    localparam logic [31:0]     BITMAP_ON = 32'd255;
    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- src/medical_pixel_sample_fetch_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// medical_pixel_sample_fetch_unit: pixel sample offset and decode
// Byte offset of one sample, its decoded value and running min / max.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_item) takes one item naming
//   a sample by col, row, chan and frame_index together with the raw word
//   read at that sample. Response channel (rsp_valid / rsp_stall / rsp_item)
//   returns byte offset, decoded value and running min / max.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the block is idle.
// Sequencing:
//   The offset is built by one shared 32x32 multiplier under a five-step
//   sequencer, followed by a done state that updates min / max and loads the
//   output register; the next item is taken only once the sequencer is idle.
//   Planar layout also needs (chan*frame_bytes)/channel_count from a
//   bit-serial divider of 34 steps started at accept; the last sequencer step
//   waits until its quotient is ready.
//   req_stall is high from accept until the result sits in the output
//   register; a new item is taken while that result still waits.
// Reset:
//   State and config registers take their defaults, min / max empty values;
//   no item is in flight. A waiting result is dropped, payloads are not reset.
// ----------------------------------------------------------------------------
module medical_pixel_sample_fetch_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire mpsf_pkg::req_item_t req_item,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output mpsf_pkg::rsp_item_t      rsp_item
);

    // configuration registers
    logic [4:0]  bits_stored_reg;
    logic [2:0]  bytes_per_value_reg;
    logic [4:0]  right_shift_reg;
    logic        is_signed_reg;
    logic        is_planar_reg;
    logic [2:0]  channel_count_reg;
    logic [15:0] image_width_reg;
    logic [31:0] frame_bytes_reg;

    // sequencer and datapath
    mpsf_pkg::state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] stride_reg, stride_next;
    logic [15:0] col_reg, row_reg, frame_reg;
    logic [1:0]  chan_reg;
    logic        restart_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic        rsp_valid_reg, rsp_valid_next;
    mpsf_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    // divider for the planar plane offset
    logic [5:0]  div_cnt_reg;
    logic [mpsf_pkg::DIV_BITS-1:0] div_q_reg;
    logic [2:0]  div_r_reg;
    logic [3:0]  div_trial;
    logic        div_fits;

    logic        accept;
    logic        bitmap;
    logic [2:0]  cc_eff;
    logic [5:0]  lane_bytes;
    logic [31:0] mul_a, mul_b;
    logic [31:0] mul_p;
    logic [31:0] dec_value;
    logic [33:0] plane_prod;

    assign accept     = req_valid && !req_stall;
    assign bitmap     = (bits_stored_reg == 5'd1);
    assign cc_eff     = (channel_count_reg == 3'd0) ? 3'd1 : channel_count_reg;
    // bytes stepped per column: one sample in planar, a whole pixel otherwise
    assign lane_bytes = is_planar_reg ? {3'd0, bytes_per_value_reg}
                                      : 6'(cc_eff) * 6'(bytes_per_value_reg);

    // chan * frame_bytes, chan being two bits
    assign plane_prod = (req_item.chan[1] ? {1'b0, frame_bytes_reg, 1'b0} : 34'd0)
                      + (req_item.chan[0] ? {2'b00, frame_bytes_reg} : 34'd0);

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        logic [31:0] cut;
        logic [31:0] shifted;
        logic [31:0] sign;
        logic [31:0] mask;
        cut = 32'd0;
        unique case (bytes_per_value_reg)
            3'd0, 3'd1: cut = {24'd0, req_item.raw_word[7:0]};
            3'd2:       cut = {16'd0, req_item.raw_word[15:0]};
            3'd3:       cut = {8'd0, req_item.raw_word[23:0]};
            default:    cut = req_item.raw_word;
        endcase
        shifted = cut >> right_shift_reg;
        if (is_signed_reg)
        begin
            sign = 32'd1 << (bits_stored_reg - 5'd1);
            mask = sign - 32'd1;
        end
        else
        begin
            sign = 32'd0;
            mask = (32'd1 << bits_stored_reg) - 32'd1;
        end
        if (bitmap)
            dec_value = req_item.raw_word[req_item.col[2:0]] ? mpsf_pkg::BITMAP_ON : 32'd0;
        else if (bits_stored_reg == 5'd0)
            dec_value = 32'd0;
        else if ((shifted & sign) != 32'd0)
            dec_value = (shifted & mask) | ~mask;   // extend the sign bit upward
        else
            dec_value = shifted & mask;
    end

    // ------------------------------------------------------ multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (step_reg)
            mpsf_pkg::STEP_FRAME:
            begin
                mul_a = {16'd0, frame_reg};
                mul_b = frame_bytes_reg;
            end
            mpsf_pkg::STEP_STRIDE:
            begin
                mul_a = bitmap ? {19'd0, image_width_reg[15:3]} : {16'd0, image_width_reg};
                mul_b = bitmap ? 32'd1 : {26'd0, lane_bytes};
            end
            mpsf_pkg::STEP_ROW:
            begin
                mul_a = {16'd0, row_reg};
                mul_b = stride_reg;
            end
            mpsf_pkg::STEP_COL:
            begin
                mul_a = bitmap ? {19'd0, col_reg[15:3]} : {16'd0, col_reg};
                mul_b = bitmap ? 32'd1 : {26'd0, lane_bytes};
            end
            default:
            begin
                mul_a = {30'd0, chan_reg};
                mul_b = {29'd0, bytes_per_value_reg};
            end
        endcase
    end

    // offsets wrap modulo 2^32, so only the low half of the product is kept
    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------- sequencer
    always_comb
    begin
        logic signed [31:0] base_min;
        logic signed [31:0] base_max;
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        stride_next    = stride_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = (state_reg != mpsf_pkg::ST_IDLE);
        base_min       = restart_reg ? mpsf_pkg::MIN_RESET : min_reg;
        base_max       = restart_reg ? mpsf_pkg::MAX_RESET : max_reg;

        unique case (state_reg)
            mpsf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mpsf_pkg::ST_CALC;
                    step_next  = mpsf_pkg::STEP_FRAME;
                end
            end
            mpsf_pkg::ST_CALC:
            begin
                priority case (step_reg)
                    mpsf_pkg::STEP_FRAME:
                    begin
                        acc_next  = mul_p[31:0];
                        step_next = mpsf_pkg::STEP_STRIDE;
                    end
                    mpsf_pkg::STEP_STRIDE:
                    begin
                        stride_next = mul_p[31:0];
                        step_next   = mpsf_pkg::STEP_ROW;
                    end
                    mpsf_pkg::STEP_ROW, mpsf_pkg::STEP_COL:
                    begin
                        acc_next  = acc_reg + mul_p[31:0];
                        step_next = step_reg + 3'd1;
                    end
                    default:
                    begin
                        // hold the last step until the plane offset is out
                        if (bitmap)
                            state_next = mpsf_pkg::ST_DONE;
                        else if (!is_planar_reg)
                        begin
                            acc_next   = acc_reg + mul_p[31:0];
                            state_next = mpsf_pkg::ST_DONE;
                        end
                        else if (div_cnt_reg == 6'd0)
                        begin
                            acc_next   = acc_reg + div_q_reg[31:0];
                            state_next = mpsf_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            default:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    min_next = (value_reg < base_min) ? value_reg : base_min;
                    max_next = (value_reg > base_max) ? value_reg : base_max;
                    rsp_item_next.byte_offset  = acc_reg;
                    rsp_item_next.sample_value = value_reg;
                    rsp_item_next.min_value    = min_next;
                    rsp_item_next.max_value    = max_next;
                    rsp_valid_next = 1'b1;
                    state_next     = mpsf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpsf_pkg::ST_IDLE;
            step_reg      <= mpsf_pkg::STEP_FRAME;
            rsp_valid_reg <= 1'b0;
            min_reg       <= mpsf_pkg::MIN_RESET;
            max_reg       <= mpsf_pkg::MAX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        stride_reg   <= stride_next;
        rsp_item_reg <= rsp_item_next;
        if (accept)
        begin
            col_reg     <= req_item.col;
            row_reg     <= req_item.row;
            chan_reg    <= req_item.chan;
            frame_reg   <= req_item.frame_index;
            restart_reg <= req_item.restart;
            value_reg   <= dec_value;
        end
    end

    // ------------------------------------------------- plane offset divider
    assign div_trial = {div_r_reg, div_q_reg[mpsf_pkg::DIV_BITS-1]};
    assign div_fits  = (div_trial >= {1'b0, cc_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= 6'd0;
        else if (accept)
            div_cnt_reg <= mpsf_pkg::DIV_STEPS;
        else if (div_cnt_reg != 6'd0)
            div_cnt_reg <= div_cnt_reg - 6'd1;
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            div_q_reg <= plane_prod;
            div_r_reg <= 3'd0;
        end
        else if (div_cnt_reg != 6'd0)
        begin
            div_q_reg <= {div_q_reg[mpsf_pkg::DIV_BITS-2:0], div_fits};
            div_r_reg <= div_fits ? 3'(div_trial - {1'b0, cc_eff}) : div_trial[2:0];
        end
    end

    // ------------------------------------------------- configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_stored_reg     <= 5'd8;
            bytes_per_value_reg <= 3'd1;
            right_shift_reg     <= 5'd0;
            is_signed_reg       <= 1'b0;
            is_planar_reg       <= 1'b0;
            channel_count_reg   <= 3'd1;
            image_width_reg     <= 16'd1;
            frame_bytes_reg     <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mpsf_pkg::REG_BITS_STORED:     bits_stored_reg     <= cfg_data[4:0];
                mpsf_pkg::REG_BYTES_PER_VALUE: bytes_per_value_reg <= cfg_data[2:0];
                mpsf_pkg::REG_RIGHT_SHIFT:     right_shift_reg     <= cfg_data[4:0];
                mpsf_pkg::REG_IS_SIGNED:       is_signed_reg       <= cfg_data[0];
                mpsf_pkg::REG_IS_PLANAR:       is_planar_reg       <= cfg_data[0];
                mpsf_pkg::REG_CHANNEL_COUNT:   channel_count_reg   <= cfg_data[2:0];
                mpsf_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data[15:0];
                default:                       frame_bytes_reg     <= cfg_data;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // ------------------------------------------------------------ assertions
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mpsf_pkg::ST_CALC) && (step_reg == mpsf_pkg::STEP_FRAME))
        else $error("accepted item did not start the offset sequence");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpsf_pkg::ST_CALC) |-> (step_reg <= mpsf_pkg::STEP_CHAN))
        else $error("sequencer step out of range");

    a_value_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.min_value <= rsp_item.sample_value)
                      && (rsp_item.sample_value <= rsp_item.max_value))
        else $error("result value lies outside running min / max");

endmodule
`default_nettype wire

// ----- bench/mpsf_sample_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsf_sample_checker: result scoreboard of the pixel sample fetch unit
// Follows register writes and accepted requests, computes the offset,
// decoded value and running min / max of each sample, and compares every
// accepted response against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mpsf_sample_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                req_valid,
    input  logic                req_stall,
    input  mpsf_pkg::req_item_t req_item,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  mpsf_pkg::rsp_item_t rsp_item,
    output int                  errors,
    output int                  pending
);

    // shadow copy of the configuration registers
    logic [4:0]  bits_stored_q;
    logic [2:0]  bytes_per_value_q;
    logic [4:0]  right_shift_q;
    logic        signed_q;
    logic        planar_q;
    logic [2:0]  chan_count_q;
    logic [15:0] width_q;
    logic [31:0] frame_bytes_q;

    logic signed [31:0] low_q;
    logic signed [31:0] high_q;

    mpsf_pkg::rsp_item_t expected_samples[$];
    mpsf_pkg::rsp_item_t want;
    int                  fail_count;

    function automatic logic [31:0] decode_sample(input logic [31:0] raw);
        logic [31:0] v;
        logic [31:0] sign;
        logic [31:0] mask;
        case (bytes_per_value_q)
            3'd0, 3'd1: v = {24'd0, raw[7:0]};
            3'd2:       v = {16'd0, raw[15:0]};
            3'd3:       v = {8'd0, raw[23:0]};
            default:    v = raw;
        endcase
        v = v >> right_shift_q;
        if (bits_stored_q == 5'd0)
            return 32'd0;
        if (signed_q)
        begin
            sign = 32'd1 << (bits_stored_q - 5'd1);
            mask = sign - 32'd1;
        end
        else
        begin
            sign = 32'd0;
            mask = (32'd1 << bits_stored_q) - 32'd1;
        end
        if ((v & sign) != 32'd0)
            return (v & mask) - sign;
        return v & mask;
    endfunction

    // offset, value and running extremes of one sample; advances min / max
    function automatic mpsf_pkg::rsp_item_t fetch_sample(input mpsf_pkg::req_item_t it);
        logic [63:0]         cc;
        logic [63:0]         bpv;
        logic [63:0]         width;
        logic [63:0]         fb;
        logic [63:0]         row;
        logic [63:0]         col;
        logic [63:0]         chan;
        logic [63:0]         frame;
        logic [63:0]         offset;
        logic [31:0]         value;
        mpsf_pkg::rsp_item_t res;
        cc     = (chan_count_q == 3'd0) ? 64'd1 : {61'd0, chan_count_q};
        bpv    = {61'd0, bytes_per_value_q};
        width  = {48'd0, width_q};
        fb     = {32'd0, frame_bytes_q};
        row    = {48'd0, it.row};
        col    = {48'd0, it.col};
        chan   = {62'd0, it.chan};
        frame  = {48'd0, it.frame_index};
        offset = frame * fb;
        if (bits_stored_q == 5'd1)
        begin
            offset = offset + row * (width / 64'd8) + col / 64'd8;
            value  = it.raw_word[it.col[2:0]] ? mpsf_pkg::BITMAP_ON : 32'd0;
        end
        else
        begin
            if (planar_q)
                offset = offset + row * width * bpv + (chan * fb) / cc + col * bpv;
            else
                offset = offset + row * width * bpv * cc + chan * bpv + col * cc * bpv;
            value = decode_sample(it.raw_word);
        end
        if (it.restart)
        begin
            low_q  = mpsf_pkg::MIN_RESET;
            high_q = mpsf_pkg::MAX_RESET;
        end
        if ($signed(value) < low_q)
            low_q = value;
        if ($signed(value) > high_q)
            high_q = value;
        res.byte_offset  = offset[31:0];
        res.sample_value = value;
        res.min_value    = low_q;
        res.max_value    = high_q;
        return res;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] exp_v,
                                         input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_stored_q     = 5'd8;
            bytes_per_value_q = 3'd1;
            right_shift_q     = 5'd0;
            signed_q          = 1'b0;
            planar_q          = 1'b0;
            chan_count_q      = 3'd1;
            width_q           = 16'd1;
            frame_bytes_q     = 32'd0;
            low_q             = mpsf_pkg::MIN_RESET;
            high_q            = mpsf_pkg::MAX_RESET;
            expected_samples.delete();
            fail_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // compare before queuing, so a response never matches its own request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: response with none expected, got %h", $time, rsp_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    fail_count += field_differs("byte_offset", want.byte_offset,
                                                rsp_item.byte_offset);
                    fail_count += field_differs("sample_value", want.sample_value,
                                                rsp_item.sample_value);
                    fail_count += field_differs("min_value", want.min_value,
                                                rsp_item.min_value);
                    fail_count += field_differs("max_value", want.max_value,
                                                rsp_item.max_value);
                end
            end
            if (req_valid && !req_stall)
                expected_samples.push_back(fetch_sample(req_item));
            if (cfg_write)
            begin
                case (cfg_index)
                    mpsf_pkg::REG_BITS_STORED:     bits_stored_q     = cfg_data[4:0];
                    mpsf_pkg::REG_BYTES_PER_VALUE: bytes_per_value_q = cfg_data[2:0];
                    mpsf_pkg::REG_RIGHT_SHIFT:     right_shift_q     = cfg_data[4:0];
                    mpsf_pkg::REG_IS_SIGNED:       signed_q          = cfg_data[0];
                    mpsf_pkg::REG_IS_PLANAR:       planar_q          = cfg_data[0];
                    mpsf_pkg::REG_CHANNEL_COUNT:   chan_count_q      = cfg_data[2:0];
                    mpsf_pkg::REG_IMAGE_WIDTH:     width_q           = cfg_data[15:0];
                    mpsf_pkg::REG_FRAME_BYTES:     frame_bytes_q     = cfg_data;
                    default:                       ;
                endcase
            end
            errors  <= fail_count;
            pending <= expected_samples.size();
        end
    end

endmodule

// ----- bench/medical_pixel_sample_fetch_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medical_pixel_sample_fetch_unit_test: stimulus and verdict for the fetch unit
// Runs a short directed set over the layouts and decode corner cases, then
// random samples under a series of random and extreme register settings,
// with bursty requests and a patterned response stall. The scoreboard module
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module medical_pixel_sample_fetch_unit_test;

    localparam int LIMIT_NS      = 10_000_000;  // hard limit on simulated time
    localparam int SETTLE_CYCLES = 40;          // planar divider plus output stage
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 50;

    // one full register setting, written as a whole between phases
    typedef struct {
        logic [4:0]  bits_stored;
        logic [2:0]  bytes_per_value;
        logic [4:0]  right_shift;
        logic        is_signed;
        logic        is_planar;
        logic [2:0]  channel_count;
        logic [15:0] image_width;
        logic [31:0] frame_bytes;
    } setup_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_write = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_data  = '0;
    logic                req_valid = 1'b0;
    mpsf_pkg::req_item_t req_item  = '0;
    logic                rsp_stall = 1'b0;
    logic                req_stall;
    logic                rsp_valid;
    mpsf_pkg::rsp_item_t rsp_item;
    int                  errors;
    int                  pending;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [2:0]  stall_tick = '0;

    medical_pixel_sample_fetch_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    mpsf_sample_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost response ends up here.
    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Receiver: each time a mode runs out, switch at random between no stall, light
    // random stall, heavy random stall and a fixed 5-of-8 stall pattern.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 3'd1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick < 3'd5);
        endcase
    end

    function automatic mpsf_pkg::req_item_t sample(input logic [15:0] col,
                                                   input logic [15:0] row,
                                                   input logic [1:0] chan,
                                                   input logic [15:0] frame,
                                                   input logic [31:0] raw,
                                                   input logic restart);
        mpsf_pkg::req_item_t s;
        s.col         = col;
        s.row         = row;
        s.chan        = chan;
        s.frame_index = frame;
        s.raw_word    = raw;
        s.restart     = restart;
        return s;
    endfunction

    // Coordinates are half small, half full range: small ones keep offsets
    // readable in a dump, full ones push every bit and the 2^32 wrap.
    function automatic mpsf_pkg::req_item_t random_sample();
        mpsf_pkg::req_item_t s;
        s.col         = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 63));
        s.row         = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 63));
        s.chan        = 2'($urandom_range(0, 3));
        s.frame_index = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 7));
        s.raw_word    = $urandom();
        s.restart     = ($urandom_range(0, 11) == 0);
        return s;
    endfunction

    function automatic setup_t make_setup(input logic [4:0] bits, input logic [2:0] bpv,
                                          input logic [4:0] shift, input logic sgn,
                                          input logic planar, input logic [2:0] cc,
                                          input logic [15:0] width, input logic [31:0] fb);
        setup_t s;
        s.bits_stored     = bits;
        s.bytes_per_value = bpv;
        s.right_shift     = shift;
        s.is_signed       = sgn;
        s.is_planar       = planar;
        s.channel_count   = cc;
        s.image_width     = width;
        s.frame_bytes     = fb;
        return s;
    endfunction

    // Bitmap mode about a quarter of the time; zero bits, zero channels and
    // odd byte counts are all allowed through.
    function automatic setup_t random_setup();
        setup_t s;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: s.bits_stored = 5'd1;
            5:             s.bits_stored = 5'd0;
            default:       s.bits_stored = 5'($urandom_range(2, 31));
        endcase
        s.bytes_per_value = 3'($urandom_range(0, 7));
        s.right_shift     = ($urandom_range(0, 4) < 3) ? 5'($urandom_range(0, 7))
                                                       : 5'($urandom_range(0, 31));
        s.is_signed       = 1'($urandom_range(0, 1));
        s.is_planar       = 1'($urandom_range(0, 1));
        s.channel_count   = 3'($urandom_range(0, 7));
        s.image_width     = $urandom_range(0, 1) ? 16'($urandom_range(1, 1024))
                                                 : 16'($urandom());
        case ($urandom_range(0, 9))
            0, 1:    s.frame_bytes = 32'd0;
            2, 3, 4: s.frame_bytes = $urandom_range(0, 65536);
            default: s.frame_bytes = $urandom();
        endcase
        return s;
    endfunction

    // Fill the bits above a register's width with noise; the block must drop them.
    function automatic logic [31:0] pad(input logic [31:0] v, input int w);
        logic [63:0] keep;
        keep = (64'd1 << w) - 64'd1;
        return ($urandom() & ~keep[31:0]) | v;
    endfunction

    // Write all eight registers on consecutive edges, then drop the enable.
    task automatic load_setup(input setup_t s);
        logic [31:0] value [8];
        value[mpsf_pkg::REG_BITS_STORED]     = pad({27'd0, s.bits_stored}, 5);
        value[mpsf_pkg::REG_BYTES_PER_VALUE] = pad({29'd0, s.bytes_per_value}, 3);
        value[mpsf_pkg::REG_RIGHT_SHIFT]     = pad({27'd0, s.right_shift}, 5);
        value[mpsf_pkg::REG_IS_SIGNED]       = pad({31'd0, s.is_signed}, 1);
        value[mpsf_pkg::REG_IS_PLANAR]       = pad({31'd0, s.is_planar}, 1);
        value[mpsf_pkg::REG_CHANNEL_COUNT]   = pad({29'd0, s.channel_count}, 3);
        value[mpsf_pkg::REG_IMAGE_WIDTH]     = pad({16'd0, s.image_width}, 16);
        value[mpsf_pkg::REG_FRAME_BYTES]     = s.frame_bytes;
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= value[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Present one item and hold it until the edge that accepts it. Valid is
    // raised here and never lowered in the same step, so back-to-back calls
    // keep it high across items.
    task automatic send_sample(input mpsf_pkg::req_item_t s);
        req_item  <= s;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted response has been taken.
    task automatic settle_block();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Random samples in bursts. Between bursts: no gap, a short or long gap,
    // or now and then a full pause until the block has drained.
    task automatic feed_samples(input int count, input logic steady);
        int left;
        int burst;
        int pause_kind;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                send_sample(random_sample());
                left--;
            end
            pause_kind = steady ? 19 : $urandom_range(0, 19);
            if (pause_kind == 0)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            else if (pause_kind < 9)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, pause_kind < 5 ? 3 : 40)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        // hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: one unsigned byte, one channel, width 1, frame size 0.
        send_sample(sample(16'd0, 16'd0, 2'd0, 16'd0, 32'd0, 1'b0));
        send_sample(sample(16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        settle_block();

        // Bitmap mode with a width that is not a multiple of 8; planar, sign,
        // shift and byte count must all be ignored.
        load_setup(make_setup(5'd1, 3'd2, 5'd5, 1'b1, 1'b1, 3'd3, 16'd12, 32'd1000));
        send_sample(sample(16'd5, 16'd3, 2'd2, 16'd1, 32'h0000_0020, 1'b0));
        send_sample(sample(16'd13, 16'd0, 2'd1, 16'd0, 32'hFFFF_FFDF, 1'b0));
        send_sample(sample(16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 32'h0000_0080, 1'b1));
        settle_block();

        // Signed 12-bit in two bytes, channel count zero, widest width and
        // frame: most negative, most positive, channel beyond count with wrap.
        load_setup(make_setup(5'd12, 3'd2, 5'd4, 1'b1, 1'b0, 3'd0, 16'hFFFF, 32'hFFFF_FFFF));
        send_sample(sample(16'd1, 16'd2, 2'd0, 16'd0, 32'h0000_8000, 1'b1));
        send_sample(sample(16'd2, 16'd0, 2'd0, 16'd1, 32'h0000_7FF0, 1'b0));
        send_sample(sample(16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample(16'd0, 16'd0, 2'd1, 16'd0, 32'd0, 1'b1));
        settle_block();

        // Zero bits stored and zero bytes per value; planar with seven channels.
        load_setup(make_setup(5'd0, 3'd0, 5'd0, 1'b0, 1'b1, 3'd7, 16'd300, 32'h1234_5677));
        send_sample(sample(16'd299, 16'd7, 2'd3, 16'd2, 32'h5A5A_A5A5, 1'b0));
        send_sample(sample(16'd0, 16'd0, 2'd0, 16'd0, 32'hFFFF_FFFF, 1'b0));
        settle_block();

        // Widest unsigned sample, bytes per value above four.
        load_setup(make_setup(5'd31, 3'd7, 5'd0, 1'b0, 1'b1, 3'd3, 16'd640, 32'd921600));
        send_sample(sample(16'd639, 16'd479, 2'd2, 16'd3, 32'hFFFF_FFFF, 1'b1));
        send_sample(sample(16'd10, 16'd20, 2'd1, 16'd0, 32'd0, 1'b0));
        settle_block();

        // Widest signed sample after a shift: both ends of its range.
        load_setup(make_setup(5'd31, 3'd4, 5'd1, 1'b1, 1'b1, 3'd4, 16'd512, 32'hFFFF_FFFF));
        send_sample(sample(16'd5, 16'd6, 2'd3, 16'd7, 32'h8000_0000, 1'b1));
        send_sample(sample(16'd8, 16'd9, 2'd2, 16'd1, 32'h7FFF_FFFE, 1'b0));
        settle_block();

        // Three-byte values with five interleaved channels.
        load_setup(make_setup(5'd20, 3'd3, 5'd3, 1'b1, 1'b0, 3'd5, 16'd1000, 32'd50000));
        send_sample(sample(16'd999, 16'd11, 2'd3, 16'd4, 32'hFF80_0000, 1'b0));
        send_sample(sample(16'd0, 16'd1, 2'd0, 16'd0, 32'h0013_FFF8, 1'b0));
        settle_block();

        // Random part: the all-low and all-high settings first, then random
        // ones. Every fourth phase runs the sender with no gaps at all.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                load_setup(make_setup(5'd0, 3'd0, 5'd0, 1'b0, 1'b0, 3'd0, 16'd0, 32'd0));
            else if (phase == 1)
                load_setup(make_setup(5'd31, 3'd7, 5'd31, 1'b1, 1'b1, 3'd7, 16'hFFFF,
                                      32'hFFFF_FFFF));
            else
                load_setup(random_setup());
            feed_samples(PHASE_ITEMS, (phase % 4) == 3);
            settle_block();
        end

        // let any stray response show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mpsf_pkg.sv
src/medical_pixel_sample_fetch_unit.sv
bench/mpsf_sample_checker.sv
bench/medical_pixel_sample_fetch_unit_test.sv
